@@ rtl/core/mep_pkg.sv @@
package mep_pkg;

    localparam int FRAC_W      = 26;
    localparam int PIX_X_W     = 10;
    localparam int PIX_Y_W     = 11;
    localparam int OFF_W       = 13;
    localparam int Z_W         = 32;
    localparam int CPROD_W     = OFF_W + Z_W;
    localparam int PROD_W      = 2 * Z_W;
    localparam int WIDE_W      = 48;
    localparam int THIRD_W     = 11;
    localparam int THIRD_CMP_W = 13;
    localparam int CNT_W       = 13;
    localparam int ITER_W      = 12;
    localparam int COL_W       = 8;
    localparam int NUM_W       = THIRD_W + COL_W;
    localparam int DIV_STEP_W  = 3;
    localparam int STEP_W      = 31;
    localparam int ESC_W       = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 40;

    localparam int DEF_IMG_WIDTH  = 720;
    localparam int DEF_IMG_HEIGHT = 1280;
    localparam int DEF_MAX_THIRD  = 1024;

    localparam logic signed [Z_W-1:0]  RST_CENTER_RE  = -32'sd43620762;
    localparam logic signed [Z_W-1:0]  RST_CENTER_IM  = 32'sd26843546;
    localparam logic [STEP_W-1:0]      RST_PIXEL_STEP = 31'd9321;
    localparam logic [THIRD_W-1:0]     RST_THIRD_ITER = 11'd128;
    localparam logic [ESC_W-1:0]       RST_ESCAPE_SQ  = 31'd603979776;

    localparam logic [COL_W-1:0] COL_FULL = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_RE  = 3'd0,
        REG_CENTER_IM  = 3'd1,
        REG_PIXEL_STEP = 3'd2,
        REG_THIRD_ITER = 3'd3,
        REG_ESCAPE_SQ  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BAND_BLUE    = 2'd0,
        BAND_MAGENTA = 2'd1,
        BAND_WHITE   = 2'd2,
        BAND_BLACK   = 2'd3
    } band_t;

    typedef struct packed {
        logic load_pix;
        logic c_mul;
        logic c_add;
        logic z_mul;
        logic z_upd;
        logic mod_start;
        logic out_load;
    } mep_cmd_t;

    typedef struct packed {
        logic iter_end;
        logic div_done;
    } mep_status_t;

    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [WIDE_W-1:0] v);
        logic signed [Z_W-1:0] res;
        if (v[WIDE_W-1:Z_W-1] == '0 || v[WIDE_W-1:Z_W-1] == '1) begin
            res = v[Z_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(Z_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(Z_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/mep_div.sv @@
module mep_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mep_pkg::NUM_W-1:0]     num,
    input  logic [mep_pkg::THIRD_W-1:0]   den,
    output logic [mep_pkg::COL_W-1:0]     quot,
    output logic                          done
);
    import mep_pkg::*;

    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]      dvs_reg, dvs_next;
    logic [COL_W-1:0]      q_reg, q_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = num;
            dvs_next  = NUM_W'(den) << (COL_W - 1);
            q_next    = '0;
            step_next = DIV_STEP_W'(COL_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= dvs_reg) begin
                rem_next = rem_reg - dvs_reg;
                q_next   = {q_reg[COL_W-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[COL_W-2:0], 1'b0};
            end
            dvs_next  = dvs_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        q_reg    <= q_next;
        step_reg <= step_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

@@ rtl/core/mep_datapath.sv @@
module mep_datapath #(
    parameter int IMG_WIDTH  = mep_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT = mep_pkg::DEF_IMG_HEIGHT,
    parameter int MAX_THIRD  = mep_pkg::DEF_MAX_THIRD
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [mep_pkg::PIX_X_W-1:0]     pix_x,
    input  logic [mep_pkg::PIX_Y_W-1:0]     pix_y,
    input  mep_pkg::mep_cmd_t               cmd,
    output mep_pkg::mep_status_t            status,
    output logic [mep_pkg::ITER_W-1:0]      iter_count,
    output logic [mep_pkg::COL_W-1:0]       red,
    output logic [mep_pkg::COL_W-1:0]       green,
    output logic [mep_pkg::COL_W-1:0]       blue
);
    import mep_pkg::*;

    logic signed [Z_W-1:0]     center_re_reg, center_im_reg;
    logic [STEP_W-1:0]         pixel_step_reg;
    logic [THIRD_W-1:0]        third_iter_reg;
    logic [ESC_W-1:0]          escape_sq_reg;

    logic [PIX_X_W-1:0]        px_reg;
    logic [PIX_Y_W-1:0]        py_reg;
    logic signed [CPROD_W-1:0] pre_reg, pim_reg;
    logic signed [Z_W-1:0]     cr_reg, ci_reg;
    logic signed [Z_W-1:0]     zr_reg, zi_reg;
    logic signed [PROD_W-1:0]  rr_reg, ii_reg, ri_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      first_reg;
    band_t                     band_reg;
    logic [ITER_W-1:0]         iter_reg;
    logic [COL_W-1:0]          red_reg, green_reg, blue_reg;

    logic [THIRD_W-1:0]        t_eff;
    logic [CNT_W-1:0]          t_cnt, t2_cnt, limit;
    logic [OFF_W-1:0]          off_x, off_y;
    logic signed [Z_W-1:0]     step_s;
    logic signed [PROD_W-1:0]  diff;
    logic [PROD_W-1:0]         mag_sum;
    logic [PROD_W-FRAC_W-1:0]  mag;
    logic                      escape;
    logic [CNT_W-1:0]          count_inc;
    logic signed [Z_W-1:0]     nr, ni;
    logic [CNT_W-1:0]          rem_cnt;
    logic [NUM_W-1:0]          div_num;
    logic [COL_W-1:0]          col;
    logic                      iter_end;
    logic                      div_done;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_re_reg  <= RST_CENTER_RE;
            center_im_reg  <= RST_CENTER_IM;
            pixel_step_reg <= RST_PIXEL_STEP;
            third_iter_reg <= RST_THIRD_ITER;
            escape_sq_reg  <= RST_ESCAPE_SQ;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_CENTER_RE:  center_re_reg  <= cfg_data;
                REG_CENTER_IM:  center_im_reg  <= cfg_data;
                REG_PIXEL_STEP: pixel_step_reg <= cfg_data[STEP_W-1:0];
                REG_THIRD_ITER: third_iter_reg <= cfg_data[THIRD_W-1:0];
                REG_ESCAPE_SQ:  escape_sq_reg  <= cfg_data[ESC_W-1:0];
                default: ;
            endcase
        end
    end

    // band length clamp and limit
    always_comb begin
        if (third_iter_reg == '0) begin
            t_eff = THIRD_W'(1);
        end else if (THIRD_CMP_W'(third_iter_reg) > THIRD_CMP_W'(MAX_THIRD)) begin
            t_eff = THIRD_W'(MAX_THIRD);
        end else begin
            t_eff = third_iter_reg;
        end
    end

    assign t_cnt  = CNT_W'(t_eff);
    assign t2_cnt = t_cnt << 1;
    assign limit  = t2_cnt + t_cnt;

    assign off_x  = OFF_W'(px_reg) - OFF_W'(IMG_WIDTH / 2);
    assign off_y  = OFF_W'(py_reg) - OFF_W'(IMG_HEIGHT / 2);
    assign step_s = $signed({1'b0, pixel_step_reg});

    // iteration update
    assign diff    = rr_reg - ii_reg;
    assign mag_sum = rr_reg + ii_reg;
    assign mag     = mag_sum[PROD_W-1:FRAC_W];
    assign escape  = mag > (PROD_W-FRAC_W)'(escape_sq_reg);
    assign count_inc = count_reg + 1'b1;

    assign nr = sat_z({{(WIDE_W-PROD_W+FRAC_W){diff[PROD_W-1]}}, diff[PROD_W-1:FRAC_W]}
                    + {{(WIDE_W-Z_W){cr_reg[Z_W-1]}}, cr_reg});
    assign ni = sat_z({{(WIDE_W-PROD_W+FRAC_W-1){ri_reg[PROD_W-1]}},
                       ri_reg[PROD_W-1:FRAC_W-1]}
                    + {{(WIDE_W-Z_W){ci_reg[Z_W-1]}}, ci_reg});

    assign iter_end = !first_reg && (escape || (count_inc == limit));
    assign status   = {iter_end, div_done};

    // count mod band length, numerator for color
    always_comb begin
        if (count_reg >= t2_cnt) begin
            rem_cnt = count_reg - t2_cnt;
        end else if (count_reg >= t_cnt) begin
            rem_cnt = count_reg - t_cnt;
        end else begin
            rem_cnt = count_reg;
        end
        div_num = (NUM_W'(rem_cnt) << COL_W) - NUM_W'(rem_cnt);
    end

    mep_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mod_start),
        .num     (div_num),
        .den     (t_eff),
        .quot    (col),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_pix) begin
            px_reg <= pix_x;
            py_reg <= pix_y;
        end
        if (cmd.c_mul) begin
            pre_reg <= $signed(off_x) * step_s;
            pim_reg <= $signed(off_y) * step_s;
        end
        if (cmd.c_add) begin
            cr_reg <= sat_z({{(WIDE_W-Z_W){center_re_reg[Z_W-1]}}, center_re_reg}
                          + {{(WIDE_W-CPROD_W){pre_reg[CPROD_W-1]}}, pre_reg});
            ci_reg <= sat_z({{(WIDE_W-Z_W){center_im_reg[Z_W-1]}}, center_im_reg}
                          - {{(WIDE_W-CPROD_W){pim_reg[CPROD_W-1]}}, pim_reg});
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= CNT_W'(1);
            first_reg <= 1'b1;
        end
        if (cmd.z_mul) begin
            rr_reg <= zr_reg * zr_reg;
            ii_reg <= zi_reg * zi_reg;
            ri_reg <= zr_reg * zi_reg;
        end
        if (cmd.z_upd) begin
            zr_reg    <= nr;
            zi_reg    <= ni;
            first_reg <= 1'b0;
            if (!first_reg && !escape) begin
                count_reg <= count_inc;
            end
        end
        if (cmd.mod_start) begin
            if (count_reg == limit) begin
                band_reg <= BAND_BLACK;
            end else if (count_reg > t2_cnt) begin
                band_reg <= BAND_WHITE;
            end else if (count_reg > t_cnt) begin
                band_reg <= BAND_MAGENTA;
            end else begin
                band_reg <= BAND_BLUE;
            end
        end
        if (cmd.out_load) begin
            iter_reg <= count_reg[ITER_W-1:0];
            case (band_reg)
                BAND_BLUE: begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= col;
                end
                BAND_MAGENTA: begin
                    red_reg   <= col;
                    green_reg <= '0;
                    blue_reg  <= COL_FULL;
                end
                BAND_WHITE: begin
                    red_reg   <= COL_FULL;
                    green_reg <= col;
                    blue_reg  <= COL_FULL;
                end
                default: begin
                    red_reg   <= '0;
                    green_reg <= '0;
                    blue_reg  <= '0;
                end
            endcase
        end
    end

    assign iter_count = iter_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;

endmodule

@@ rtl/core/mep_ctrl.sv @@
module mep_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output mep_pkg::mep_cmd_t     cmd,
    input  mep_pkg::mep_status_t  status
);
    import mep_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_CMUL = 8'b0000_0010,
        ST_CADD = 8'b0000_0100,
        ST_ZMUL = 8'b0000_1000,
        ST_ZUPD = 8'b0001_0000,
        ST_MOD  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_pix = 1'b1;
                    state_next   = ST_CMUL;
                end
            end
            ST_CMUL: begin
                cmd.c_mul  = 1'b1;
                state_next = ST_CADD;
            end
            ST_CADD: begin
                cmd.c_add  = 1'b1;
                state_next = ST_ZMUL;
            end
            ST_ZMUL: begin
                cmd.z_mul  = 1'b1;
                state_next = ST_ZUPD;
            end
            ST_ZUPD: begin
                cmd.z_upd  = 1'b1;
                state_next = status.iter_end ? ST_MOD : ST_ZMUL;
            end
            ST_MOD: begin
                cmd.mod_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for a free output slot
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/core/mandelbrot_escape_pixel.sv @@
// Mandelbrot escape-time evaluator for one pixel per input beat.
// Input stream: s_tdata carries the pixel column and row; the block maps it to a
// point c of the complex plane from the center and pixel step registers and
// iterates z = z*z + c until |z|^2 exceeds escape_sq or the count reaches
// 3*third_iter. Output stream: m_tdata carries the count and an RGB color.
// Configuration: cfg_valid/cfg_index/cfg_data write one register per beat,
// cfg_ready is always high; write only while no pixel is in flight.
// Flow: one pixel at a time. Each iteration passes through the three 32x32
// multipliers and then the update/escape stage. The iterations follow the point
// setup and are followed by the band selection and the 8-step color divider.
// A new input beat is taken the cycle after the result enters the output
// register, while that result may still wait for m_tready.
// Stall: with m_tready low the result is held; the next pixel is computed and
// waits in its last step until the output register is free.
// Reset: aresetn (synchronous, active low) empties the block and restores the
// register defaults.
module mandelbrot_escape_pixel #(
    parameter int IMG_WIDTH  = mep_pkg::DEF_IMG_WIDTH,
    parameter int IMG_HEIGHT = mep_pkg::DEF_IMG_HEIGHT,
    parameter int MAX_THIRD  = mep_pkg::DEF_MAX_THIRD
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mep_pkg::S_TDATA_W-1:0]   s_tdata,   // pix_x, pix_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mep_pkg::M_TDATA_W-1:0]   m_tdata,   // iter_count, red, green, blue
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mep_pkg::*;

    mep_cmd_t          cmd;
    mep_status_t       status;
    logic [ITER_W-1:0] iter_count;
    logic [COL_W-1:0]  red, green, blue;

    assign cfg_ready = 1'b1;

    mep_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mep_datapath #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT),
        .MAX_THIRD  (MAX_THIRD)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_x      (s_tdata[PIX_X_W-1:0]),
        .pix_y      (s_tdata[PIX_X_W+PIX_Y_W-1:PIX_X_W]),
        .cmd        (cmd),
        .status     (status),
        .iter_count (iter_count),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign m_tdata = {{(M_TDATA_W-ITER_W-3*COL_W){1'b0}}, blue, green, red, iter_count};

    // one pixel at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pixel is in flight");

    // a fresh result only comes out of the last step, never from idle
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a pixel in flight");

    // color bands: red implies full blue, green implies full red
    a_band_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (red != '0) |-> blue == COL_FULL)
        else $error("red set outside the upper bands");

    a_band_green: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (green != '0) |-> red == COL_FULL && blue == COL_FULL)
        else $error("green set outside the top band");

endmodule
